[design/fbpa_pkg.sv]
package fbpa_pkg;

  localparam int MAX_BLOCKS    = 256;
  localparam int POINTER_BYTES = 4;

  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W     = 32;
  localparam int POOL_W     = 24;
  localparam int SIZE_W     = 16;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_STEPS  = POOL_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam kind_t KIND_INIT = 2'd0;
  localparam kind_t KIND_GET  = 2'd1;
  localparam kind_t KIND_PUT  = 2'd2;

  localparam cfg_idx_t REG_POOL_BASE   = 2'd0;
  localparam cfg_idx_t REG_POOL_BYTES  = 2'd1;
  localparam cfg_idx_t REG_BLOCK_BYTES = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_TOO_BIG  = 2'd3
  } status_t;

endpackage

[design/fbpa_in_if.sv]
interface fbpa_in_if;
  import fbpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [7:0]        block_index;

  modport source (output valid, output kind, output block_index, input ready);
  modport sink   (input valid, input kind, input block_index, output ready);
endinterface

[design/fbpa_out_if.sv]
interface fbpa_out_if;
  import fbpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [7:0]          granted_index;
  logic [ADDR_W-1:0]   granted_address;
  logic [8:0]          free_blocks;
  logic [8:0]          low_watermark;
  logic [8:0]          total_blocks;
  logic [SIZE_W-1:0]   effective_block_bytes;

  modport source (
    output valid, output status, output granted_index, output granted_address,
    output free_blocks, output low_watermark, output total_blocks,
    output effective_block_bytes, input ready
  );
  modport sink (
    input valid, input status, input granted_index, input granted_address,
    input free_blocks, input low_watermark, input total_blocks,
    input effective_block_bytes, output ready
  );
endinterface

[design/fbpa_ram.sv]
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/fixed_block_pool_allocator.sv]
// Channel   Dir  Handshake      Beat
// in_ch     in   valid/ready    kind, block_index
// out_ch    out  valid/ready    status, granted_index/address, counts, block size
// cfg       in   cfg_we         cfg_index, cfg_wdata (no read-back)
//
// Put, unused kind, get on an empty pool and an oversized init: result registered in
// the cycle after accept.
// Get: waits in S_GET for the synchronous read of the link memory.
// Init: runs the restoring divider in S_DIV, then one link write per block in S_CHAIN
// (up to 256 blocks). Input is held off while busy or the result register is full.
// Reset clears control state only; the link memory is not cleared.
module fixed_block_pool_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  fbpa_in_if.sink                         in_ch,
  fbpa_out_if.source                      out_ch
);
  import fbpa_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_GET, S_DIV, S_CHAIN} state_t;

  state_t              state_r;
  logic [ADDR_W-1:0]   pool_base_r;
  logic [POOL_W-1:0]   pool_bytes_r;
  logic [SIZE_W-1:0]   block_bytes_r;

  logic [IDX_W-1:0]    head_r;
  logic                head_valid_r;
  logic [CNT_W-1:0]    free_r;
  logic [CNT_W-1:0]    max_r;
  logic [CNT_W-1:0]    min_r;
  logic [SIZE_W-1:0]   size_r;

  logic [SIZE_W-1:0]   eff_r;
  logic [SIZE_W-1:0]   rem_r;
  logic [POOL_W-1:0]   quo_r;
  logic [STEP_W-1:0]   step_r;
  logic [CNT_W-1:0]    chain_r;
  logic [CNT_W-1:0]    count_r;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [IDX_W-1:0]    out_gidx_r;
  logic [ADDR_W-1:0]   out_gaddr_r;
  logic [CNT_W-1:0]    out_free_r;
  logic [CNT_W-1:0]    out_min_r;
  logic [CNT_W-1:0]    out_total_r;
  logic [SIZE_W-1:0]   out_size_r;

  logic                in_ready;
  logic                accept;
  logic [SIZE_W-1:0]   eff;
  logic                too_big;
  logic                pool_full;
  logic [SIZE_W:0]     trial;
  logic [SIZE_W:0]     diff;
  logic                ge;
  logic [SIZE_W-1:0]   rem_nxt;
  logic [POOL_W-1:0]   quo_nxt;
  logic [CNT_W-1:0]    count_nxt;
  logic [CNT_W-1:0]    chain_inc;
  logic [CNT_W-1:0]    free_dec;
  logic [CNT_W-1:0]    free_inc;
  logic [POOL_W-1:0]   product;
  logic [ADDR_W-1:0]   gaddr;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [IDX_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]    ram_rdata;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept   = in_ready && in_ch.valid;

  assign eff       = (block_bytes_r < SIZE_W'(POINTER_BYTES)) ?
                     SIZE_W'(POINTER_BYTES) : block_bytes_r;
  assign too_big   = {{(POOL_W-SIZE_W){1'b0}}, eff} > pool_bytes_r;
  assign pool_full = free_r >= max_r;
  assign free_dec  = free_r - CNT_W'(1);
  assign free_inc  = free_r + CNT_W'(1);

  // restoring divider step
  assign trial     = {rem_r, quo_r[POOL_W-1]};
  assign diff      = trial - {1'b0, eff_r};
  assign ge        = trial >= {1'b0, eff_r};
  assign rem_nxt   = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
  assign quo_nxt   = {quo_r[POOL_W-2:0], ge};
  assign count_nxt = (quo_nxt > POOL_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) :
                     quo_nxt[CNT_W-1:0];

  assign chain_inc = chain_r + CNT_W'(1);

  assign product = POOL_W'(head_r) * POOL_W'(size_r);
  assign gaddr   = pool_base_r + ADDR_W'(product);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chain_r[IDX_W-1:0];
    ram_wdata = (chain_inc < count_r) ? chain_inc[IDX_W-1:0] : '0;
    if (state_r == S_CHAIN) begin
      ram_we = 1'b1;
    end else if (accept && in_ch.kind == KIND_PUT && !pool_full) begin
      ram_we    = 1'b1;
      ram_waddr = in_ch.block_index[IDX_W-1:0];
      ram_wdata = head_valid_r ? head_r : '0;
    end
  end

  fbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pool_base_r   <= '0;
      pool_bytes_r  <= '0;
      block_bytes_r <= '0;
      head_r        <= '0;
      head_valid_r  <= 1'b0;
      free_r        <= '0;
      max_r         <= '0;
      min_r         <= '0;
      size_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POOL_BASE:   pool_base_r   <= cfg_wdata[ADDR_W-1:0];
          REG_POOL_BYTES:  pool_bytes_r  <= cfg_wdata[POOL_W-1:0];
          REG_BLOCK_BYTES: block_bytes_r <= cfg_wdata[SIZE_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ch.ready && !accept) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_gidx_r   <= '0;
            out_gaddr_r  <= '0;
            out_min_r    <= min_r;
            out_total_r  <= max_r;
            out_size_r   <= size_r;
            case (in_ch.kind)
              KIND_INIT: begin
                out_free_r <= free_r;
                if (too_big) begin
                  out_status_r <= ST_TOO_BIG;
                  out_valid_r  <= 1'b1;
                end else begin
                  out_status_r <= ST_OK;
                  out_valid_r  <= 1'b0;
                  eff_r        <= eff;
                  rem_r        <= '0;
                  quo_r        <= pool_bytes_r;
                  step_r       <= '0;
                  state_r      <= S_DIV;
                end
              end
              KIND_GET: begin
                out_free_r <= free_r;
                if (free_r == '0) begin
                  out_status_r <= ST_EMPTY;
                  out_valid_r  <= 1'b1;
                end else begin
                  out_status_r <= ST_OK;
                  out_valid_r  <= 1'b0;
                  state_r      <= S_GET;
                end
              end
              KIND_PUT: begin
                if (pool_full) begin
                  out_status_r <= ST_FULL;
                  out_free_r   <= free_r;
                end else begin
                  out_status_r <= ST_OK;
                  head_r       <= in_ch.block_index[IDX_W-1:0];
                  head_valid_r <= 1'b1;
                  free_r       <= free_inc;
                  out_free_r   <= free_inc;
                end
                out_valid_r <= 1'b1;
              end
              default: begin
                out_status_r <= ST_OK;
                out_free_r   <= free_r;
                out_valid_r  <= 1'b1;
              end
            endcase
          end
        end

        S_GET: begin
          out_gidx_r  <= head_r;
          out_gaddr_r <= gaddr;
          out_free_r  <= free_dec;
          free_r      <= free_dec;
          if (min_r > free_dec) begin
            min_r     <= free_dec;
            out_min_r <= free_dec;
          end
          if (free_dec != '0) begin
            head_r <= ram_rdata;
          end else begin
            head_r       <= '0;
            head_valid_r <= 1'b0;
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end

        S_DIV: begin
          rem_r  <= rem_nxt;
          quo_r  <= quo_nxt;
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(DIV_STEPS - 1)) begin
            count_r <= count_nxt;
            chain_r <= '0;
            state_r <= S_CHAIN;
          end
        end

        S_CHAIN: begin
          chain_r <= chain_inc;
          if (chain_inc == count_r) begin
            head_r       <= '0;
            head_valid_r <= 1'b1;
            free_r       <= count_r;
            max_r        <= count_r;
            min_r        <= count_r;
            size_r       <= eff_r;
            out_free_r   <= count_r;
            out_min_r    <= count_r;
            out_total_r  <= count_r;
            out_size_r   <= eff_r;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready                  = in_ready;
  assign out_ch.valid                 = out_valid_r;
  assign out_ch.status                = out_status_r;
  assign out_ch.granted_index         = out_gidx_r;
  assign out_ch.granted_address       = out_gaddr_r;
  assign out_ch.free_blocks           = out_free_r;
  assign out_ch.low_watermark         = out_min_r;
  assign out_ch.total_blocks          = out_total_r;
  assign out_ch.effective_block_bytes = out_size_r;

endmodule

[design/fbpa_checker.sv]
module fbpa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [fbpa_pkg::STATUS_W-1:0]  status,
  input logic [7:0]                     granted_index,
  input logic [fbpa_pkg::ADDR_W-1:0]    granted_address,
  input logic [8:0]                     free_blocks,
  input logic [8:0]                     low_watermark,
  input logic [8:0]                     total_blocks
);
  import fbpa_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result beat stalled");

  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (low_watermark <= free_blocks) && (free_blocks <= total_blocks))
    else $error("free count outside watermark or total");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != ST_OK) |-> (granted_index == '0) && (granted_address == '0))
    else $error("grant fields set on failed beat");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .status          (out_ch.status),
  .granted_index   (out_ch.granted_index),
  .granted_address (out_ch.granted_address),
  .free_blocks     (out_ch.free_blocks),
  .low_watermark   (out_ch.low_watermark),
  .total_blocks    (out_ch.total_blocks)
);
